@@ sv/pamt_pkg.sv @@
package pamt_pkg;

  localparam int VAL_W   = 48;
  localparam int POS_W   = 10;
  localparam int FUNC_W  = 2;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 3;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [POS_W-1:0]        pos_t;
  typedef logic [FUNC_W-1:0]       func_t;

  // operation codes carried in func
  localparam func_t FUNC_CHMAX = 2'd0;
  localparam func_t FUNC_ADD   = 2'd1;
  localparam func_t FUNC_QUERY = 2'd2;
  localparam func_t FUNC_NOP   = 2'd3;

  // register map, indexed by word address
  localparam logic [PADDR_W-3:0] REG_LAST_INDEX = '0;
  localparam pos_t               LAST_INDEX_RST = 10'd1023;

  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // one tree node: subtree maximum and pending add tag
  typedef struct packed {
    val_t mx;
    val_t pend;
  } node_t;

  typedef enum logic {
    ALU_TAG,
    ALU_MAX
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    node_t   node;
    val_t    arg;
  } alu_req_t;

endpackage

@@ sv/pamt_alu.sv @@
module pamt_alu (
  input  pamt_pkg::alu_req_t req,
  output pamt_pkg::node_t    res
);
  import pamt_pkg::*;

  function automatic val_t sat_add(input val_t a, input val_t b);
    logic signed [VAL_W:0] s;
    begin
      s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
      if (s[VAL_W] != s[VAL_W-1]) begin
        sat_add = s[VAL_W] ? VAL_MIN : VAL_MAX;
      end else begin
        sat_add = s[VAL_W-1:0];
      end
    end
  endfunction

  // tag: add arg to both fields with saturation; max: raise mx to arg
  always_comb begin
    unique case (req.op)
      ALU_TAG: begin
        res.mx   = sat_add(req.node.mx, req.arg);
        res.pend = sat_add(req.node.pend, req.arg);
      end
      ALU_MAX: begin
        res.mx   = (req.arg > req.node.mx) ? req.arg : req.node.mx;
        res.pend = req.node.pend;
      end
      default: begin
        res = req.node;
      end
    endcase
  end

endmodule

@@ sv/pamt_mem.sv @@
module pamt_mem #(
  parameter int AW = 11
) (
  input  logic            clk,
  input  logic            re,
  input  logic [AW-1:0]   ra_addr,
  input  logic [AW-1:0]   rb_addr,
  output pamt_pkg::node_t ra_data,
  output pamt_pkg::node_t rb_data,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  pamt_pkg::node_t wdata
);
  import pamt_pkg::*;

  node_t mem [2**AW];

  // one write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // two registered read ports, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      ra_data <= mem[ra_addr];
      rb_data <= mem[rb_addr];
    end
  end

endmodule

@@ sv/prefix_add_prefix_max_tree_core.sv @@
// Lazy segment tree over positions 0..last_index (capped at LEAVES-1) holding
// 48-bit saturating values, all zero after reset. func selects point chmax,
// prefix add or prefix max query; every item returns one beat (max_value for
// a query, else zero; error when position is beyond last_index, with nothing
// changed). After reset all 2**($clog2(LEAVES)+1) node memory entries (2048 at
// the default size) are cleared before the first item is taken. An item walks
// the tree one level at a time through a single node memory with one write port
// and one saturating add/max unit: each internal level descended passes through
// check, read, left and right push-down (plus a left add for a prefix add that
// branches right) and step; chmax and add then climb back one level at a time
// to recombine maxima, and entry and exit pass through load and done. An error
// or unused func code goes straight to done. A finished beat waits in the output
// register while the next item is accepted.
module prefix_add_prefix_max_tree_core #(
  parameter int LEAVES = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pamt_pkg::PADDR_W-1:0]  paddr,
  input  logic [pamt_pkg::DATA_W-1:0]   pwdata,
  output logic [pamt_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pamt_pkg::func_t               func,
  input  pamt_pkg::pos_t                position,
  input  pamt_pkg::val_t                value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pamt_pkg::val_t                max_value,
  output logic                          error
);
  import pamt_pkg::*;

  localparam int AW     = $clog2(LEAVES) + 1;
  localparam int SD     = $clog2(LEAVES) + 1;
  localparam int SIW    = $clog2(SD);
  localparam int TOP_LIM = (LEAVES - 1 < (1 << POS_W) - 1) ? LEAVES - 1 : (1 << POS_W) - 1;
  localparam pos_t TOP_CAP = POS_W'(TOP_LIM);

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_LOAD = 4'd2;
  localparam logic [3:0] ST_CHK  = 4'd3;
  localparam logic [3:0] ST_RD   = 4'd4;
  localparam logic [3:0] ST_SL   = 4'd5;
  localparam logic [3:0] ST_SR   = 4'd6;
  localparam logic [3:0] ST_AL   = 4'd7;
  localparam logic [3:0] ST_STEP = 4'd8;
  localparam logic [3:0] ST_UP   = 4'd9;
  localparam logic [3:0] ST_DONE = 4'd10;

  logic [3:0]     state;
  logic [AW-1:0]  clr_cnt;
  pos_t           last_index;

  func_t          func_q;
  pos_t           pos_q;
  val_t           val_q;
  logic [AW-1:0]  k;
  pos_t           lo;
  pos_t           hi;
  logic [SIW-1:0] d;
  node_t          cur;
  node_t          left;
  node_t          right;
  val_t           acc;
  val_t           res;
  logic           err_q;
  val_t           sib [SD];

  pos_t           top;
  logic           start_ok;
  logic [POS_W:0] mid_sum;
  pos_t           mid;
  logic           go_right;
  logic           term;
  logic           out_free;
  logic [SIW-1:0] d_dec;
  logic           cfg_wr;

  alu_req_t       alu_req;
  node_t          alu_out;

  logic           mem_re;
  logic [AW-1:0]  ra_addr;
  logic [AW-1:0]  rb_addr;
  node_t          rd_a;
  node_t          rd_b;
  logic           mem_we;
  logic [AW-1:0]  waddr;
  node_t          wdata;

  pamt_alu u_alu (
    .req (alu_req),
    .res (alu_out)
  );

  pamt_mem #(
    .AW (AW)
  ) u_mem (
    .clk     (clk),
    .re      (mem_re),
    .ra_addr (ra_addr),
    .rb_addr (rb_addr),
    .ra_data (rd_a),
    .rb_data (rd_b),
    .we      (mem_we),
    .waddr   (waddr),
    .wdata   (wdata)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[PADDR_W-1:2] == REG_LAST_INDEX)
                  ? {{(DATA_W-POS_W){1'b0}}, last_index} : '0;

  // tree shape and walk decisions
  assign top      = (last_index > TOP_CAP) ? TOP_CAP : last_index;
  assign start_ok = (func != FUNC_NOP) && (position <= top);
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid      = mid_sum[POS_W:1];
  assign go_right = pos_q > mid;
  assign term     = (lo >= hi) || ((hi == pos_q) && (func_q != FUNC_CHMAX));
  assign out_free = !out_valid || !out_stall;
  assign d_dec    = d - 1'b1;
  assign in_stall = (state != ST_IDLE);

  // shared unit operands
  always_comb begin
    alu_req = '{op: ALU_TAG, node: '0, arg: '0};
    unique case (state)
      ST_CHK: begin
        if (func_q == FUNC_QUERY) begin
          alu_req = '{op: ALU_MAX, node: '{mx: acc, pend: '0}, arg: cur.mx};
        end else if (func_q == FUNC_ADD) begin
          alu_req = '{op: ALU_TAG, node: cur, arg: val_q};
        end else begin
          alu_req = '{op: ALU_MAX, node: cur, arg: val_q};
        end
      end
      ST_SL:   alu_req = '{op: ALU_TAG, node: rd_a, arg: cur.pend};
      ST_SR:   alu_req = '{op: ALU_TAG, node: rd_b, arg: cur.pend};
      ST_AL:   alu_req = '{op: ALU_TAG, node: left, arg: val_q};
      ST_STEP: alu_req = '{op: ALU_MAX, node: '{mx: acc, pend: '0}, arg: left.mx};
      ST_UP:   alu_req = '{op: ALU_MAX, node: cur, arg: sib[d_dec]};
      default: alu_req = '{op: ALU_TAG, node: '0, arg: '0};
    endcase
  end

  // node memory access
  always_comb begin
    mem_re  = 1'b0;
    ra_addr = AW'(1);
    rb_addr = AW'(1);
    mem_we  = 1'b0;
    waddr   = k;
    wdata   = '0;
    unique case (state)
      ST_CLR: begin
        mem_we = 1'b1;
        waddr  = clr_cnt;
      end
      ST_IDLE: begin
        mem_re = in_valid && start_ok;
      end
      ST_CHK: begin
        mem_we = term;
        wdata  = (func_q == FUNC_QUERY) ? cur : alu_out;
      end
      ST_RD: begin
        mem_re  = 1'b1;
        ra_addr = {k[AW-2:0], 1'b0};
        rb_addr = {k[AW-2:0], 1'b1};
        mem_we  = 1'b1;
        wdata   = '{mx: cur.mx, pend: '0};
      end
      ST_STEP: begin
        mem_we = 1'b1;
        if (go_right) begin
          waddr = {k[AW-2:0], 1'b0};
          wdata = left;
        end else begin
          waddr = {k[AW-2:0], 1'b1};
          wdata = right;
        end
      end
      ST_UP: begin
        mem_we = (d != '0);
        waddr  = k >> 1;
        wdata  = '{mx: alu_out.mx, pend: '0};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // sequencer, register and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLR;
      clr_cnt    <= '0;
      out_valid  <= 1'b0;
      last_index <= LAST_INDEX_RST;
    end else begin
      if (cfg_wr && (paddr[PADDR_W-1:2] == REG_LAST_INDEX)) begin
        last_index <= pwdata[POS_W-1:0];
      end
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            state <= start_ok ? ST_LOAD : ST_DONE;
          end
        end
        ST_LOAD: state <= ST_CHK;
        ST_CHK: begin
          if (!term) begin
            state <= ST_RD;
          end else if (func_q == FUNC_QUERY) begin
            state <= ST_DONE;
          end else begin
            state <= ST_UP;
          end
        end
        ST_RD: state <= ST_SL;
        ST_SL: state <= ST_SR;
        ST_SR: state <= (func_q == FUNC_ADD && go_right) ? ST_AL : ST_STEP;
        ST_AL: state <= ST_STEP;
        ST_STEP: state <= ST_CHK;
        ST_UP: begin
          if (d == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          func_q <= func;
          pos_q  <= position;
          val_q  <= value;
          k      <= AW'(1);
          lo     <= '0;
          hi     <= top;
          d      <= '0;
          acc    <= VAL_MIN;
          res    <= '0;
          err_q  <= (func != FUNC_NOP) && (position > top);
        end
      end
      ST_LOAD: cur <= rd_a;
      ST_CHK: begin
        if (term) begin
          if (func_q == FUNC_QUERY) begin
            res <= alu_out.mx;
          end else begin
            cur <= alu_out;
          end
        end
      end
      ST_SL: left  <= alu_out;
      ST_SR: right <= alu_out;
      ST_AL: left  <= alu_out;
      ST_STEP: begin
        d <= d + 1'b1;
        if (go_right) begin
          cur    <= right;
          k      <= {k[AW-2:0], 1'b1};
          lo     <= mid + POS_W'(1);
          sib[d] <= left.mx;
          if (func_q == FUNC_QUERY) begin
            acc <= alu_out.mx;
          end
        end else begin
          cur    <= left;
          k      <= {k[AW-2:0], 1'b0};
          hi     <= mid;
          sib[d] <= right.mx;
        end
      end
      ST_UP: begin
        if (d != '0) begin
          cur <= alu_out;
          k   <= k >> 1;
          d   <= d_dec;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          max_value <= res;
          error     <= err_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ sv/pamt_checker.sv @@
module pamt_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input pamt_pkg::val_t max_value,
  input logic           error
);
  import pamt_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(max_value) && $stable(error))
    else $error("result beat changed while stalled");

  // a rejected operation reports no value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> max_value == '0)
    else $error("error beat carries a nonzero max_value");

  // one item at a time: busy right after an accepted beat
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  // clearing pass keeps the input closed after reset
  a_clear: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("input open or result shown right after reset");

endmodule

bind prefix_add_prefix_max_tree_core pamt_checker u_pamt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .max_value (max_value),
  .error     (error)
);
